/* design/tfp_pkg.sv */
// shared types and codes for the touch frame parser
`timescale 1ns / 1ps

package tfp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_XFER_OK   = 2'd1,
    OP_XFER_FAIL = 2'd2
  } tfp_op_kind_t;

  typedef struct packed {
    tfp_op_kind_t kind;
    logic [7:0]   data_byte;
    logic [1:0]   transfer_code;
  } tfp_op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic        new_sample;
    logic        big_object;
    logic [2:0]  point_total;
    logic [3:0]  touch_id;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
    logic [7:0]  area;
    logic        recover_request;
    logic        last;
  } tfp_result_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_XFER   = 2'd2;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NOT_READY = 3'd4;

  localparam logic [1:0] XFER_OK = 2'd0;

  localparam logic CFG_DEVICE_READY      = 1'b0;
  localparam logic CFG_RECOVER_THRESHOLD = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

/* design/touch_frame_parser.sv */
// top level of the touch frame parser
// an accepted word passes through the front register, then the queue, then the result register
// throughput: one input word per cycle while out_stall is low
// results wait in an output register; the front keeps taking words until
// the two-entry queue and the front register are both full
// reset (rst_n low, synchronous) clears frame position and error count, and sets config to not ready, threshold 3
`timescale 1ns / 1ps

module touch_frame_parser #(
  parameter int SLOT_COUNT = 5,
  parameter int SLOT_BYTES = 8,
  parameter int MAX_POINTS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_transfer_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_status,
  output logic        out_new_sample,
  output logic        out_big_object,
  output logic [2:0]  out_point_total,
  output logic [3:0]  out_touch_id,
  output logic [11:0] out_x_coord,
  output logic [11:0] out_y_coord,
  output logic [7:0]  out_area,
  output logic        out_recover_request,
  output logic        out_last
);
  import tfp_pkg::*;

  logic        push;
  tfp_op_t     push_op;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  tfp_op_t     head_op;
  tfp_result_t res;

  tfp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_transfer_code (in_transfer_code),
    .push             (push),
    .push_op          (push_op),
    .q_full           (q_full)
  );

  tfp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head_op (head_op)
  );

  tfp_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES),
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind            = res.kind;
  assign out_status          = res.status;
  assign out_new_sample      = res.new_sample;
  assign out_big_object      = res.big_object;
  assign out_point_total     = res.point_total;
  assign out_touch_id        = res.touch_id;
  assign out_x_coord         = res.x_coord;
  assign out_y_coord         = res.y_coord;
  assign out_area            = res.area;
  assign out_recover_request = res.recover_request;
  assign out_last            = res.last;

endmodule

/* design/tfp_front.sv */
// front stage: takes input words and classifies them into operations
`timescale 1ns / 1ps

module tfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_func,
  input  logic [7:0]      in_data_byte,
  input  logic [1:0]      in_transfer_code,
  output logic            push,
  output tfp_pkg::tfp_op_t push_op,
  input  logic            q_full
);
  import tfp_pkg::*;

  logic    front_valid_r;
  logic    front_valid_nxt;
  tfp_op_t front_r;
  tfp_op_t front_nxt;
  logic    accept;

  assign in_stall = front_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid_r && !q_full;
  assign push_op  = front_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_nxt       = front_r;
    if (accept) begin
      front_valid_nxt         = 1'b1;
      front_nxt.data_byte     = in_data_byte;
      front_nxt.transfer_code = in_transfer_code;
      if (!in_func) begin
        front_nxt.kind = OP_BYTE;
      end else if (in_transfer_code == XFER_OK) begin
        front_nxt.kind = OP_XFER_OK;
      end else begin
        front_nxt.kind = OP_XFER_FAIL;
      end
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    front_r <= front_nxt;
  end

endmodule

/* design/tfp_queue.sv */
// short operation queue between front and back
`timescale 1ns / 1ps

module tfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tfp_pkg::tfp_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tfp_pkg::tfp_op_t head_op
);
  import tfp_pkg::*;

  tfp_op_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign head_op = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/tfp_back.sv */
// back stage: frame state, point assembly, error counter and result register
`timescale 1ns / 1ps

module tfp_back #(
  parameter int SLOT_COUNT = 5,
  parameter int SLOT_BYTES = 8,
  parameter int MAX_POINTS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                q_valid,
  input  tfp_pkg::tfp_op_t    head_op,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tfp_pkg::tfp_result_t out_res
);
  import tfp_pkg::*;

  localparam int LIMIT  = (MAX_POINTS < SLOT_COUNT) ? MAX_POINTS : SLOT_COUNT;
  localparam int PTS_W  = $clog2(LIMIT + 1);
  localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W  = 5;

  localparam logic [3:0] LIMIT_NIB = 4'(LIMIT);
  localparam logic [2:0] OFF_LAST  = 3'(SLOT_BYTES - 1);
  localparam logic [2:0] OFF_ID    = 3'd0;
  localparam logic [2:0] OFF_XLO   = 3'd1;
  localparam logic [2:0] OFF_XHI   = 3'd2;
  localparam logic [2:0] OFF_YLO   = 3'd3;
  localparam logic [2:0] OFF_YHI   = 3'd4;
  localparam logic [2:0] OFF_AREA  = 3'd5;

  logic              device_ready_r;
  logic [7:0]        threshold_r;
  logic              at_hdr_r,  at_hdr_nxt;
  logic [SLOT_W-1:0] slot_r,    slot_nxt;
  logic [2:0]        off_r,     off_nxt;
  logic [PTS_W-1:0]  points_r,  points_nxt;
  logic [3:0]        id_r,      id_nxt;
  logic [11:0]       x_r,       x_nxt;
  logic [11:0]       y_r,       y_nxt;
  logic [7:0]        err_r,     err_nxt;
  logic              out_valid_r;
  tfp_result_t       res_r,     res_nxt;
  logic              emit;
  logic              out_free;
  logic [7:0]        b;
  logic [3:0]        cnt_nib;
  logic [7:0]        err_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = q_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign b         = head_op.data_byte;
  assign cnt_nib   = (b[3:0] > LIMIT_NIB) ? LIMIT_NIB : b[3:0];
  assign err_inc   = (err_r == 8'hFF) ? err_r : err_r + 8'd1;

  always_comb begin
    at_hdr_nxt = at_hdr_r;
    slot_nxt   = slot_r;
    off_nxt    = off_r;
    points_nxt = points_r;
    id_nxt     = id_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    res_nxt    = '0;
    emit       = 1'b0;
    unique case (head_op.kind)
      OP_BYTE: begin
        if (!device_ready_r) begin
          at_hdr_nxt     = 1'b1;
          emit           = 1'b1;
          res_nxt.kind   = KIND_HEADER;
          res_nxt.status = STATUS_NOT_READY;
          res_nxt.last   = 1'b1;
        end else if (at_hdr_r) begin
          at_hdr_nxt   = 1'b0;
          slot_nxt     = '0;
          off_nxt      = '0;
          emit         = 1'b1;
          res_nxt.kind = KIND_HEADER;
          if (b[7]) begin
            points_nxt          = PTS_W'(cnt_nib);
            res_nxt.new_sample  = 1'b1;
            res_nxt.big_object  = b[6];
            res_nxt.point_total = 3'(cnt_nib);
            res_nxt.last        = (cnt_nib == 4'd0);
          end else begin
            points_nxt   = '0;
            res_nxt.last = 1'b1;
          end
        end else begin
          if (CMP_W'(slot_r) < CMP_W'(points_r)) begin
            unique case (off_r)
              OFF_ID:  id_nxt = b[3:0];
              OFF_XLO: x_nxt  = {x_r[11:8], b};
              OFF_XHI: x_nxt  = {b[3:0], x_r[7:0]};
              OFF_YLO: y_nxt  = {y_r[11:8], b};
              OFF_YHI: y_nxt  = {b[3:0], y_r[7:0]};
              OFF_AREA: begin
                emit             = 1'b1;
                res_nxt.kind     = KIND_POINT;
                res_nxt.touch_id = id_r;
                res_nxt.x_coord  = x_r;
                res_nxt.y_coord  = y_r;
                res_nxt.area     = b;
                res_nxt.last     = (CMP_W'(slot_r) + CMP_W'(1) == CMP_W'(points_r));
              end
              default: ;
            endcase
          end
          if (off_r == OFF_LAST) begin
            off_nxt = '0;
            if (slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
              at_hdr_nxt = 1'b1;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end else begin
            off_nxt = off_r + 3'd1;
          end
        end
      end
      OP_XFER_OK: begin
        err_nxt        = '0;
        emit           = 1'b1;
        res_nxt.kind   = KIND_XFER;
        res_nxt.status = STATUS_OK;
        res_nxt.last   = 1'b1;
      end
      OP_XFER_FAIL: begin
        at_hdr_nxt     = 1'b1;
        emit           = 1'b1;
        res_nxt.kind   = KIND_XFER;
        res_nxt.status = {1'b0, head_op.transfer_code};
        res_nxt.last   = 1'b1;
        if (err_inc >= threshold_r) begin
          res_nxt.recover_request = 1'b1;
          err_nxt                 = '0;
        end else begin
          err_nxt = err_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_ready_r <= 1'b0;
      threshold_r    <= 8'd3;
      at_hdr_r       <= 1'b1;
      slot_r         <= '0;
      off_r          <= '0;
      points_r       <= '0;
      err_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_READY:      device_ready_r <= cfg_data[0];
          CFG_RECOVER_THRESHOLD: threshold_r    <= cfg_data;
          default: ;
        endcase
      end
      if (pop) begin
        at_hdr_r <= at_hdr_nxt;
        slot_r   <= slot_nxt;
        off_r    <= off_nxt;
        points_r <= points_nxt;
        err_r    <= err_nxt;
      end
      if (out_free) begin
        out_valid_r <= pop && emit;
      end
    end
    if (pop) begin
      id_r <= id_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
    end
    if (pop && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule
